/* sv/tcsm_pkg.sv */
// Package with the types, codes and constants of the TCP connection state machine.
package tcsm_pkg;

  // Connection phases.
  typedef enum logic [3:0] {
    PH_CLOSED    = 4'd0,
    PH_LISTEN    = 4'd1,
    PH_SYNSENT   = 4'd2,
    PH_SYNRECV   = 4'd3,
    PH_EST       = 4'd4,
    PH_FINWAIT1  = 4'd5,
    PH_FINWAIT2  = 4'd6,
    PH_CLOSEWAIT = 4'd7,
    PH_TIMEWAIT  = 4'd8,
    PH_LASTACK   = 4'd9
  } phase_t;

  // Kind of segment to send.
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_SYN    = 3'd1,
    KIND_ACK    = 3'd2,
    KIND_FIN    = 3'd3,
    KIND_FINACK = 3'd4,
    KIND_RST    = 3'd5,
    KIND_DATA   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_NOT_CONN = 2'd2
  } status_t;

  // Event codes; the remaining codes are ignored.
  localparam logic [2:0] FUNC_SEGMENT = 3'd0;
  localparam logic [2:0] FUNC_OPEN    = 3'd1;
  localparam logic [2:0] FUNC_SEND    = 3'd2;
  localparam logic [2:0] FUNC_CLOSE   = 3'd3;
  localparam logic [2:0] FUNC_LISTEN  = 3'd4;

  // Flag byte bits.
  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [7:0] FLAG_ECE = 8'h40;

  // Flags each phase tolerates on a received segment.
  localparam logic [7:0] SYNSENT_FLAGS = FLAG_ACK | FLAG_SYN | FLAG_ECE;
  localparam logic [7:0] EST_FLAGS     = FLAG_ACK | FLAG_PSH | FLAG_FIN | FLAG_ECE;
  localparam logic [7:0] FINWAIT_FLAGS = FLAG_ACK | FLAG_FIN;

  localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [3:0]  header_words;
    logic [15:0] segment_length;
    logic [31:0] initial_seq;
    logic [15:0] send_length;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] local_seq;
    logic [31:0] remote_seq;
    logic [31:0] last_acked;
  } conn_t;

  typedef struct packed {
    status_t     status;
    kind_t       send_kind;
    logic [31:0] send_seq;
    logic [31:0] send_ack;
    logic [15:0] send_payload_len;
    logic [15:0] rx_payload_len;
    logic [5:0]  rx_payload_offset;
    logic        wake;
    phase_t      conn_state;
  } result_t;

endpackage

/* sv/tcsm_evt_if.sv */
// Interface of the event channel.
interface tcsm_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  seg_flags;
  logic [31:0] seg_seq;
  logic [31:0] seg_ack;
  logic [3:0]  header_words;
  logic [15:0] segment_length;
  logic [31:0] initial_seq;
  logic [15:0] send_length;

  modport source (
    output valid, func, seg_flags, seg_seq, seg_ack, header_words,
           segment_length, initial_seq, send_length,
    input  ready
  );
  modport sink (
    input  valid, func, seg_flags, seg_seq, seg_ack, header_words,
           segment_length, initial_seq, send_length,
    output ready
  );
endinterface

/* sv/tcsm_res_if.sv */
// Interface of the result channel.
interface tcsm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  send_kind;
  logic [31:0] send_seq;
  logic [31:0] send_ack;
  logic [15:0] send_payload_len;
  logic [15:0] rx_payload_len;
  logic [5:0]  rx_payload_offset;
  logic        wake;
  logic [3:0]  conn_state;

  modport source (
    output valid, status, send_kind, send_seq, send_ack, send_payload_len,
           rx_payload_len, rx_payload_offset, wake, conn_state,
    input  ready
  );
  modport sink (
    input  valid, status, send_kind, send_seq, send_ack, send_payload_len,
           rx_payload_len, rx_payload_offset, wake, conn_state,
    output ready
  );
endinterface

/* sv/tcsm_step.sv */
// Combinational step logic: one event against the connection state.
module tcsm_step (
  input  tcsm_pkg::item_t   item,
  input  tcsm_pkg::conn_t   conn,
  output tcsm_pkg::conn_t   conn_next,
  output tcsm_pkg::result_t result
);
  import tcsm_pkg::*;

  logic [5:0]  hdr_bytes;
  logic        hdr_ok;
  logic        seg_live;
  logic        f_fin, f_syn, f_rst, f_psh, f_ack;
  logic [15:0] data_len;
  logic        has_data;
  logic [31:0] seq_plus1;
  logic [31:0] remote_plus_data;
  logic        synsent_bad, est_bad, finwait_bad;
  logic        est_ok;

  assign hdr_bytes = {item.header_words, 2'b00};
  assign hdr_ok    = (item.header_words >= MIN_HEADER_WORDS) &&
                     (item.segment_length >= {10'd0, hdr_bytes});
  assign seg_live  = (item.func == FUNC_SEGMENT) && hdr_ok &&
                     (conn.phase != PH_CLOSED) && (conn.phase != PH_LISTEN);

  assign f_fin = |(item.seg_flags & FLAG_FIN);
  assign f_syn = |(item.seg_flags & FLAG_SYN);
  assign f_rst = |(item.seg_flags & FLAG_RST);
  assign f_psh = |(item.seg_flags & FLAG_PSH);
  assign f_ack = |(item.seg_flags & FLAG_ACK);

  assign data_len         = item.segment_length - {10'd0, hdr_bytes};
  assign has_data         = (data_len != 16'd0);
  assign seq_plus1        = item.seg_seq + 32'd1;
  assign remote_plus_data = conn.remote_seq + {16'd0, data_len};

  assign synsent_bad = |(item.seg_flags & ~SYNSENT_FLAGS);
  assign est_bad     = |(item.seg_flags & ~EST_FLAGS);
  assign finwait_bad = |(item.seg_flags & ~FINWAIT_FLAGS);

  // In-order segment that does not acknowledge beyond what was sent.
  assign est_ok = !est_bad && (item.seg_seq == conn.remote_seq) &&
                  !(f_ack && (item.seg_ack > conn.local_seq));

  // Next connection state.
  always_comb begin
    conn_next = conn;
    case (item.func)
      FUNC_SEGMENT: begin
        if (seg_live) begin
          if (f_rst) begin
            conn_next.phase = PH_CLOSED;
          end else begin
            case (conn.phase)
              PH_SYNSENT: begin
                if (!synsent_bad && f_ack && f_syn) begin
                  conn_next.remote_seq = item.seg_seq;
                  conn_next.last_acked = item.seg_ack;
                  if (item.seg_ack == conn.local_seq) begin
                    conn_next.phase      = PH_EST;
                    conn_next.remote_seq = seq_plus1;
                  end
                end
              end
              PH_SYNRECV: begin
                if (f_ack) begin
                  conn_next.remote_seq = item.seg_seq;
                  conn_next.phase      = PH_EST;
                end
              end
              PH_EST: begin
                if (est_ok) begin
                  if (f_ack) conn_next.last_acked = item.seg_ack;
                  if (has_data) conn_next.remote_seq = remote_plus_data;
                  if (f_fin) conn_next.phase = PH_CLOSEWAIT;
                end
              end
              PH_FINWAIT1: begin
                if (!finwait_bad) begin
                  if (f_fin && f_ack) begin
                    conn_next.remote_seq = seq_plus1;
                    conn_next.phase      = PH_TIMEWAIT;
                  end else if (f_ack) begin
                    conn_next.remote_seq = item.seg_seq;
                    conn_next.phase      = PH_FINWAIT2;
                  end else if (f_fin) begin
                    conn_next.remote_seq = seq_plus1;
                    conn_next.phase      = PH_LASTACK;
                  end
                end
              end
              PH_FINWAIT2: begin
                if (!finwait_bad && f_fin) begin
                  conn_next.remote_seq = seq_plus1;
                  conn_next.phase      = PH_TIMEWAIT;
                end
              end
              PH_CLOSEWAIT, PH_TIMEWAIT, PH_LASTACK: begin
                conn_next.phase = PH_CLOSED;
              end
              default: begin
              end
            endcase
          end
        end
      end
      FUNC_OPEN: begin
        if (conn.phase inside {PH_CLOSED, PH_LISTEN}) begin
          conn_next.phase     = PH_SYNSENT;
          conn_next.local_seq = item.initial_seq + 32'd1;
        end
      end
      FUNC_SEND: begin
        if (conn.phase == PH_EST)
          conn_next.local_seq = conn.local_seq + {16'd0, item.send_length};
      end
      FUNC_CLOSE: begin
        case (conn.phase)
          PH_LISTEN, PH_SYNSENT, PH_SYNRECV: conn_next.phase = PH_CLOSED;
          PH_EST:                            conn_next.phase = PH_FINWAIT1;
          PH_CLOSEWAIT:                      conn_next.phase = PH_LASTACK;
          default: begin
          end
        endcase
      end
      FUNC_LISTEN: begin
        if (conn.phase inside {PH_CLOSED, PH_LISTEN}) conn_next.phase = PH_LISTEN;
      end
      default: begin
      end
    endcase
  end

  // Result fields.
  always_comb begin
    result                   = '0;
    result.status            = ST_DROPPED;
    result.send_kind         = KIND_NONE;
    case (item.func)
      FUNC_SEGMENT: begin
        if (seg_live) begin
          if (f_rst) begin
            result.status = ST_ACCEPTED;
          end else begin
            case (conn.phase)
              PH_SYNSENT: begin
                if (!synsent_bad && f_ack && f_syn &&
                    (item.seg_ack == conn.local_seq)) begin
                  result.status    = ST_ACCEPTED;
                  result.send_kind = KIND_ACK;
                  result.send_seq  = conn.local_seq;
                  result.send_ack  = seq_plus1;
                  result.wake      = 1'b1;
                end
              end
              PH_SYNRECV: begin
                if (f_ack) begin
                  result.status = ST_ACCEPTED;
                  result.wake   = 1'b1;
                end
              end
              PH_EST: begin
                if (est_ok) begin
                  result.status = ST_ACCEPTED;
                  if (has_data) begin
                    result.send_kind         = KIND_ACK;
                    result.send_seq          = conn.local_seq;
                    result.send_ack          = remote_plus_data;
                    result.rx_payload_len    = data_len;
                    result.rx_payload_offset = hdr_bytes;
                  end
                  result.wake = has_data || f_psh;
                end
              end
              PH_FINWAIT1: begin
                if (!finwait_bad && (f_fin || f_ack)) begin
                  result.status = ST_ACCEPTED;
                  if (f_fin) begin
                    result.send_kind = f_ack ? KIND_ACK : KIND_FINACK;
                    result.send_seq  = conn.local_seq;
                    result.send_ack  = seq_plus1;
                  end
                end
              end
              PH_FINWAIT2: begin
                if (!finwait_bad && f_fin) begin
                  result.status    = ST_ACCEPTED;
                  result.send_kind = KIND_ACK;
                  result.send_seq  = conn.local_seq;
                  result.send_ack  = seq_plus1;
                end
              end
              PH_CLOSEWAIT, PH_TIMEWAIT: begin
                result.status    = ST_ACCEPTED;
                result.send_kind = KIND_RST;
                result.send_seq  = conn.local_seq;
              end
              PH_LASTACK: begin
                result.status = ST_ACCEPTED;
                if (!f_ack) begin
                  result.send_kind = KIND_RST;
                  result.send_seq  = conn.local_seq;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      FUNC_OPEN: begin
        if (conn.phase inside {PH_CLOSED, PH_LISTEN}) begin
          result.status    = ST_ACCEPTED;
          result.send_kind = KIND_SYN;
          result.send_seq  = item.initial_seq;
        end
      end
      FUNC_SEND: begin
        if (conn.phase == PH_EST) begin
          result.status           = ST_ACCEPTED;
          result.send_kind        = KIND_DATA;
          result.send_seq         = conn.local_seq;
          result.send_ack         = conn.remote_seq;
          result.send_payload_len = item.send_length;
        end else begin
          result.status = ST_NOT_CONN;
        end
      end
      FUNC_CLOSE: begin
        case (conn.phase)
          PH_LISTEN: result.status = ST_ACCEPTED;
          PH_SYNSENT, PH_SYNRECV: begin
            result.status    = ST_ACCEPTED;
            result.send_kind = KIND_RST;
            result.send_seq  = conn.local_seq;
          end
          PH_EST: begin
            result.status    = ST_ACCEPTED;
            result.send_kind = KIND_FINACK;
            result.send_seq  = conn.local_seq;
            result.send_ack  = conn.remote_seq;
          end
          PH_CLOSEWAIT: begin
            result.status    = ST_ACCEPTED;
            result.send_kind = KIND_FIN;
            result.send_seq  = conn.local_seq;
          end
          default: begin
          end
        endcase
      end
      FUNC_LISTEN: begin
        if (conn.phase inside {PH_CLOSED, PH_LISTEN}) result.status = ST_ACCEPTED;
      end
      default: begin
      end
    endcase
    result.conn_state = conn_next.phase;
  end

endmodule

/* sv/tcp_connection_state_machine.sv */
// Top level of the TCP connection state machine with its input and result registers.
//
// The block tracks one TCP connection. Events arrive on the evt channel: a received
// segment header, an open with an initial sequence number, a send of some bytes, a
// close or a listen. For every event exactly one result transaction leaves on the res
// channel: a status, the segment to send with its sequence and acknowledgement
// numbers, the accepted payload length and offset, a wake flag and the phase after
// the event. Both channels move a transaction on a clock edge with valid and ready high.
//
// An accepted event sits in the input register; the step logic evaluates it against
// the connection registers, which update at the same edge that loads the result
// register. One event is taken every cycle while the receiver does not stall, since
// the state loop is a single register stage.
//
// When the receiver stalls, the result register holds its transaction, the pending
// event waits in the input register, and evt.ready falls only once both are full.
// A synchronous reset empties both registers and returns the connection to closed
// with the local, remote and last acknowledged numbers at zero. No event is taken
// while reset is asserted.
module tcp_connection_state_machine (
  input logic        clk,
  input logic        rst,
  tcsm_evt_if.sink   evt,
  tcsm_res_if.source res
);
  import tcsm_pkg::*;

  item_t   item_q;
  logic    item_valid;
  logic    item_valid_next;
  conn_t   conn;
  conn_t   conn_next;
  result_t step_result;
  result_t res_q;
  logic    res_valid;
  logic    res_valid_next;
  logic    advance;
  logic    evt_take;

  // The pending event advances whenever the result register is free or draining.
  assign advance         = item_valid && (!res_valid || res.ready);
  assign evt.ready       = !rst && (!item_valid || advance);
  assign evt_take        = evt.valid && evt.ready;
  assign item_valid_next = evt_take || (item_valid && !advance);
  assign res_valid_next  = advance || (res_valid && !res.ready);

  tcsm_step u_step (
    .item      (item_q),
    .conn      (conn),
    .conn_next (conn_next),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      res_valid  <= 1'b0;
      conn       <= '{phase: PH_CLOSED, local_seq: 32'd0, remote_seq: 32'd0,
                      last_acked: 32'd0};
    end else begin
      item_valid <= item_valid_next;
      res_valid  <= res_valid_next;
      if (advance) conn <= conn_next;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (evt_take) begin
      item_q.func           <= evt.func;
      item_q.seg_flags      <= evt.seg_flags;
      item_q.seg_seq        <= evt.seg_seq;
      item_q.seg_ack        <= evt.seg_ack;
      item_q.header_words   <= evt.header_words;
      item_q.segment_length <= evt.segment_length;
      item_q.initial_seq    <= evt.initial_seq;
      item_q.send_length    <= evt.send_length;
    end
    if (advance) res_q <= step_result;
  end

  assign res.valid             = res_valid;
  assign res.status            = res_q.status;
  assign res.send_kind         = res_q.send_kind;
  assign res.send_seq          = res_q.send_seq;
  assign res.send_ack          = res_q.send_ack;
  assign res.send_payload_len  = res_q.send_payload_len;
  assign res.rx_payload_len    = res_q.rx_payload_len;
  assign res.rx_payload_offset = res_q.rx_payload_offset;
  assign res.wake              = res_q.wake;
  assign res.conn_state        = res_q.conn_state;

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

  // A stalled result freezes the connection registers.
  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> $stable(conn))
    else $error("connection state changed while result stalled");

  // With no event pending, the shown phase is the current phase.
  a_phase_matches: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !item_valid) |-> (res.conn_state == conn.phase))
    else $error("result phase differs from connection phase");

  // A send refused for lack of a connection emits nothing.
  a_not_conn_silent: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == ST_NOT_CONN)) |-> (res.send_kind == KIND_NONE))
    else $error("segment emitted on a refused send");

endmodule
